// File: hw/rtl/bsw_pkg.sv
// Package for the binary shrink window step: payload structs, register
// indexes and the conditional and unconditional shrink pattern tables.
// No dependencies.
`default_nettype none

package bsw_pkg;

  // Field widths fixed by the payload definition
  localparam int WIN_W   = 25;
  localparam int COORD_W = 12;
  localparam int CFG_W   = 13;

  localparam int COND_COUNT   = 58;
  localparam int UNCOND_COUNT = 37;

  // Input item
  typedef struct packed {
    logic [WIN_W-1:0]   window_bits;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
  } bsw_in_t;

  // Result item
  typedef struct packed {
    logic new_center;
    logic center_marked;
    logic center_erased;
  } bsw_out_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } bsw_reg_t;

  // A 3x3 neighborhood is held in reading order: the top left cell is
  // bit 8, the bottom right cell is bit 0, the center is bit 4.
  typedef logic [8:0] bsw_hood_t;

  // Unconditional pattern: cells that must be marked, cells that must not
  // be marked, and the A/B/C group of which at least one must be marked.
  typedef struct packed {
    bsw_hood_t one;
    bsw_hood_t zero;
    bsw_hood_t grp;
  } bsw_uncond_t;

  localparam bsw_hood_t COND_PAT [COND_COUNT] = '{
    9'b001010000, 9'b100010000, 9'b000010100, 9'b000010001,
    9'b000011000, 9'b010010000, 9'b000110000, 9'b000010010,
    9'b001011000, 9'b011010000, 9'b110010000, 9'b100110000,
    9'b000110100, 9'b000010110, 9'b000010011, 9'b000011001,
    9'b001011001, 9'b111010000, 9'b100110100, 9'b000010111,
    9'b110011000, 9'b010011001, 9'b011110000, 9'b001011010,
    9'b011011000, 9'b110110000, 9'b000110110, 9'b000011011,
    9'b110011001, 9'b011110100,
    9'b111011000, 9'b011011001, 9'b111110000, 9'b110110100,
    9'b100110110, 9'b000110111, 9'b000011111, 9'b001011011,
    9'b111011001, 9'b111110100, 9'b100110111, 9'b001011111,
    9'b011011011, 9'b111111000, 9'b110110110, 9'b000111111,
    9'b111011011, 9'b011011111, 9'b111111100, 9'b111111001,
    9'b111110110, 9'b110110111, 9'b100111111, 9'b001111111,
    9'b111011111, 9'b111111101, 9'b111110111, 9'b101111111
  };

  localparam bsw_uncond_t UNCOND_PAT [UNCOND_COUNT] = '{
    // spur
    '{9'b001010000, 9'b110101111, 9'b000000000},
    '{9'b100010000, 9'b011101111, 9'b000000000},
    // single 4-connection
    '{9'b000010010, 9'b111101101, 9'b000000000},
    '{9'b000011000, 9'b111100111, 9'b000000000},
    // L corner
    '{9'b001011000, 9'b110100111, 9'b000000000},
    '{9'b011010000, 9'b100101111, 9'b000000000},
    '{9'b110010000, 9'b001101111, 9'b000000000},
    '{9'b100110000, 9'b011001111, 9'b000000000},
    '{9'b000110100, 9'b111001011, 9'b000000000},
    '{9'b000010110, 9'b111101001, 9'b000000000},
    '{9'b000010011, 9'b111101100, 9'b000000000},
    '{9'b000011001, 9'b111100110, 9'b000000000},
    // offset corners
    '{9'b011110000, 9'b100001111, 9'b000000000},
    '{9'b110011000, 9'b001100111, 9'b000000000},
    '{9'b010011001, 9'b101100110, 9'b000000000},
    '{9'b001011010, 9'b110100101, 9'b000000000},
    // corner cluster with A/B group
    '{9'b001010100, 9'b100100011, 9'b010001000},
    '{9'b100010001, 9'b001001110, 9'b010100000},
    '{9'b001010100, 9'b110001001, 9'b000100010},
    '{9'b100010001, 9'b011100100, 9'b000001010},
    // 2x2 block
    '{9'b110110000, 9'b000000000, 9'b000000000},
    // tee branch
    '{9'b010111000, 9'b001000011, 9'b000000000},
    '{9'b010111000, 9'b100000110, 9'b000000000},
    '{9'b000111010, 9'b110000100, 9'b000000000},
    '{9'b000111010, 9'b011000001, 9'b000000000},
    '{9'b010110010, 9'b000001101, 9'b000000000},
    '{9'b010110010, 9'b101001000, 9'b000000000},
    '{9'b010011010, 9'b101100000, 9'b000000000},
    '{9'b010011010, 9'b000100101, 9'b000000000},
    // vee branch with A/B/C group
    '{9'b101010000, 9'b000000000, 9'b000000111},
    '{9'b100010100, 9'b000000000, 9'b001001001},
    '{9'b000010101, 9'b000000000, 9'b111000000},
    '{9'b001010001, 9'b000000000, 9'b100100100},
    // diagonal branch
    '{9'b010011100, 9'b001100010, 9'b000000000},
    '{9'b010110001, 9'b100001010, 9'b000000000},
    '{9'b001110010, 9'b010001100, 9'b000000000},
    '{9'b100011010, 9'b010100001, 9'b000000000}
  };

  // Exact match of a neighborhood against the conditional shrink table
  function automatic logic cond_hit(input bsw_hood_t hood);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < COND_COUNT; k++) begin
      if (hood == COND_PAT[k]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Match of a mark neighborhood against the unconditional table
  function automatic logic uncond_hit(input bsw_hood_t marks);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < UNCOND_COUNT; k++) begin
      if (((marks & UNCOND_PAT[k].one) == UNCOND_PAT[k].one) &&
          ((marks & UNCOND_PAT[k].zero) == '0) &&
          ((UNCOND_PAT[k].grp == '0) || ((marks & UNCOND_PAT[k].grp) != '0)))
        hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/binary_shrink_window_step.sv
// Top level of the binary shrink window step: input register, pattern
// matching logic and result register. Depends on bsw_pkg.
//
// Usage:
//   in_*   : one 5x5 binary window per transfer, with the row and column of its
//            center pixel. A transfer happens when in_valid and in_ready are high.
//   out_*  : one result per input window: the center after this shrink pass,
//            whether it was conditionally marked, and whether it was erased.
//   cfg_*  : writes image_width (index 0) and image_height (index 1); values
//            above MAX_SIDE are held as MAX_SIDE. cfg_ready is always high.
//            Write only while no window is in flight.
// Path: an input window is held in the input register, then in the result
//   register, which drives out_valid. Throughput: one window per cycle while
//   results are taken without stall; the 9 conditional matches and the
//   unconditional match are parallel table logic between the two registers.
// Reset: both stages empty, width 640 and height 480.
// Stall: when out_ready is low the result register holds; the input register
//   still takes one more window, after which in_ready drops until the
//   result is taken.
`default_nettype none

module binary_shrink_window_step #(
  parameter int MAX_SIDE = 4096
) (
  input  wire               clk,
  input  wire               rst_n,
  // input window channel
  input  wire               in_valid,
  output logic              in_ready,
  input  bsw_pkg::bsw_in_t  in_data,
  // result channel
  output logic              out_valid,
  input  wire               out_ready,
  output bsw_pkg::bsw_out_t out_data,
  // configuration write channel
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  bsw_pkg::bsw_reg_t cfg_index,
  input  wire [bsw_pkg::CFG_W-1:0] cfg_data
);

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int LIM_W   = (SIDE_W > bsw_pkg::CFG_W) ? SIDE_W : bsw_pkg::CFG_W;
  localparam int CMP_W   = ((SIDE_W > bsw_pkg::COORD_W) ? SIDE_W : bsw_pkg::COORD_W) + 2;
  localparam int RST_WID = (640 > MAX_SIDE) ? MAX_SIDE : 640;
  localparam int RST_HGT = (480 > MAX_SIDE) ? MAX_SIDE : 480;

  logic [SIDE_W-1:0] width_r;
  logic [SIDE_W-1:0] height_r;
  logic [LIM_W-1:0]  cfg_ext;
  logic [SIDE_W-1:0] cfg_clamped;

  bsw_pkg::bsw_in_t  s1_data_r;
  logic              s1_valid_r;
  logic              s1_adv;
  bsw_pkg::bsw_out_t out_data_r;
  bsw_pkg::bsw_out_t out_data_nxt;
  logic              out_valid_r;

  logic [2:0]         row_ok;
  logic [2:0]         col_ok;
  bsw_pkg::bsw_hood_t marks;
  bsw_pkg::bsw_hood_t hood;
  logic               center;
  logic               marked;
  logic               erased;

  // Clamp configuration data to the largest supported side
  assign cfg_ready   = 1'b1;
  assign cfg_ext     = LIM_W'(cfg_data);
  assign cfg_clamped = (cfg_ext > LIM_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                   : SIDE_W'(cfg_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_W'(RST_WID);
      height_r <= SIDE_W'(RST_HGT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsw_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_clamped;
        bsw_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // Advance the input stage whenever the result register is free or drains
  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Interior test for the three rows and columns around the center:
  // position p = base + a - 1 is interior when p >= 1 and p + 2 <= side
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      row_ok[a] = ((CMP_W'(s1_data_r.center_row) + CMP_W'(a)) >= CMP_W'(2)) &&
                  ((CMP_W'(s1_data_r.center_row) + CMP_W'(a) + CMP_W'(1)) <=
                   CMP_W'(height_r));
      col_ok[a] = ((CMP_W'(s1_data_r.center_col) + CMP_W'(a)) >= CMP_W'(2)) &&
                  ((CMP_W'(s1_data_r.center_col) + CMP_W'(a) + CMP_W'(1)) <=
                   CMP_W'(width_r));
    end
  end

  // Conditional mark for each of the nine pixels around the center
  always_comb begin
    marks = '0;
    hood  = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            hood[8 - (3 * a + b)] = s1_data_r.window_bits[5 * (dr + a) + (dc + b)];
          end
        end
        marks[8 - (3 * dr + dc)] = row_ok[dr] && col_ok[dc] && bsw_pkg::cond_hit(hood);
      end
    end
  end

  // Erase a marked center unless its marks hit an unconditional pattern
  assign center = s1_data_r.window_bits[12];
  assign marked = marks[4];
  assign erased = marked && !bsw_pkg::uncond_hit(marks);

  always_comb begin
    out_data_nxt.new_center    = center && !erased;
    out_data_nxt.center_marked = marked;
    out_data_nxt.center_erased = erased;
  end

  // Result register: load on advance, drop once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  // An erased center was marked and leaves background behind
  a_erase_marked : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.center_erased ||
                     (out_data_r.center_marked && !out_data_r.new_center)))
    else $error("erased center without mark or still foreground");

  // Only a foreground center can be marked
  a_mark_fg : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=>
      (!out_data_r.center_marked || $past(s1_data_r.window_bits[12])))
    else $error("background center was marked");

  // Side registers never exceed the supported maximum
  a_side_max : assert property (@(posedge clk) disable iff (!rst_n)
    (LIM_W'(width_r) <= LIM_W'(MAX_SIDE)) && (LIM_W'(height_r) <= LIM_W'(MAX_SIDE)))
    else $error("side register above MAX_SIDE");

  // Input back-pressure only with both stages full and the output stalled
  a_ready_low : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low without a full stalled pipeline");

endmodule

`default_nettype wire
